// ===== hw/rtl/qcnt_pkg.sv =====
package qcnt_pkg;

  localparam int unsigned ERR_W    = 32;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned OUT_POS_W = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_HOME   = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COUNT_REVERSE = 1'b0,
    CFG_HOME_OFFSET   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] phase_ab;
    logic       index_pulse;
  } item_t;

  // Place of a phase in the sequence 00, 01, 11, 10.
  function automatic logic [1:0] cycle_pos(input logic [1:0] ph);
    cycle_pos = {ph[1], ph[0] ^ ph[1]};
  endfunction

endpackage

// ===== hw/rtl/qcnt_step.sv =====
module qcnt_step #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  qcnt_pkg::item_t                item,
  input  logic                           count_reverse,
  input  logic [qcnt_pkg::OFFSET_W-1:0]  home_offset,
  input  logic [1:0]                     last_phase,
  input  logic [COUNT_WIDTH-1:0]         position,
  input  logic [qcnt_pkg::ERR_W-1:0]     invalid_jumps,
  input  logic                           homing,
  output logic [1:0]                     last_phase_next,
  output logic [COUNT_WIDTH-1:0]         position_next,
  output logic [qcnt_pkg::ERR_W-1:0]     invalid_jumps_next,
  output logic                           homing_next
);

  logic [1:0]             delta;
  logic                   fwd;
  logic                   back;
  logic                   up;
  logic                   down;
  logic                   jump;
  logic [63:0]            offset_ext;
  logic [COUNT_WIDTH-1:0] stepped;

  assign delta = qcnt_pkg::cycle_pos(item.phase_ab) - qcnt_pkg::cycle_pos(last_phase);
  assign fwd   = (delta == 2'd1);
  assign back  = (delta == 2'd3);
  assign jump  = (delta == 2'd2);
  assign up    = count_reverse ? back : fwd;
  assign down  = count_reverse ? fwd : back;

  assign offset_ext = 64'(signed'(home_offset));

  always_comb begin
    if (up) begin
      stepped = position + COUNT_WIDTH'(1);
    end else if (down) begin
      stepped = position - COUNT_WIDTH'(1);
    end else begin
      stepped = position;
    end
  end

  always_comb begin
    last_phase_next    = last_phase;
    position_next      = position;
    invalid_jumps_next = invalid_jumps;
    homing_next        = homing;
    unique case (item.req_type)
      qcnt_pkg::REQ_SAMPLE: begin
        last_phase_next = item.phase_ab;
        if (jump && (invalid_jumps != '1)) begin
          invalid_jumps_next = invalid_jumps + qcnt_pkg::ERR_W'(1);
        end
        // index while homing overrides the step
        if (homing && item.index_pulse) begin
          position_next = offset_ext[COUNT_WIDTH-1:0];
          homing_next   = 1'b0;
        end else begin
          position_next = stepped;
        end
      end
      qcnt_pkg::REQ_CLEAR: begin
        position_next = '0;
        homing_next   = 1'b0;
      end
      qcnt_pkg::REQ_HOME: begin
        homing_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/quadrature_counter_with_homing.sv =====
// Channel | Dir | Handshake            | Payload
// s       | in  | s_tvalid / s_tready  | tuser: req_type; tdata: phase_ab, index_pulse
// m       | out | m_tvalid / m_tready  | tdata: position_count, error_count, homing_active
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while m_tready keeps up; each item goes from input
// beat to result beat: input register, then decode/count into the result register.
// The counter state updates as an item moves into the result register, so the
// next item already sees it. rst clears state, config and both stages.
// A stalled result holds; the input stage still fills, then s_tready drops.
module quadrature_counter_with_homing #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [qcnt_pkg::IN_DATA_W-1:0]      s_tdata,  // phase_ab[1:0], index_pulse[2], zeros
  input  logic [qcnt_pkg::IN_USER_W-1:0]      s_tuser,  // req_type[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [qcnt_pkg::OUT_DATA_W-1:0]     m_tdata,  // position_count[31:0],
                                                        // error_count[63:32],
                                                        // homing_active[64], zeros
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qcnt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcnt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                              count_reverse;
  logic [qcnt_pkg::OFFSET_W-1:0]     home_offset;

  logic                              in_vld;
  qcnt_pkg::item_t                   in_item;
  logic                              advance;

  logic [1:0]                        last_phase;
  logic [COUNT_WIDTH-1:0]            position;
  logic [qcnt_pkg::ERR_W-1:0]        invalid_jumps;
  logic                              homing;

  logic [1:0]                        last_phase_next;
  logic [COUNT_WIDTH-1:0]            position_next;
  logic [qcnt_pkg::ERR_W-1:0]        invalid_jumps_next;
  logic                              homing_next;

  logic                              out_vld;
  logic [qcnt_pkg::OUT_POS_W-1:0]    out_pos;
  logic [qcnt_pkg::ERR_W-1:0]        out_err;
  logic                              out_homing;
  logic [63:0]                       pos_wide;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reverse <= 1'b0;
      home_offset   <= '0;
    end else if (cfg_valid) begin
      unique case (qcnt_pkg::cfg_idx_t'(cfg_index))
        qcnt_pkg::CFG_COUNT_REVERSE: count_reverse <= cfg_data[0];
        qcnt_pkg::CFG_HOME_OFFSET:   home_offset   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input stage moves on when the result register is free or being drained
  assign advance  = in_vld && (!out_vld || m_tready);
  assign s_tready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.req_type    <= s_tuser[1:0];
      in_item.phase_ab    <= s_tdata[1:0];
      in_item.index_pulse <= s_tdata[2];
    end
  end

  qcnt_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .item               (in_item),
    .count_reverse      (count_reverse),
    .home_offset        (home_offset),
    .last_phase         (last_phase),
    .position           (position),
    .invalid_jumps      (invalid_jumps),
    .homing             (homing),
    .last_phase_next    (last_phase_next),
    .position_next      (position_next),
    .invalid_jumps_next (invalid_jumps_next),
    .homing_next        (homing_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_phase    <= '0;
      position      <= '0;
      invalid_jumps <= '0;
      homing        <= 1'b0;
    end else if (advance) begin
      last_phase    <= last_phase_next;
      position      <= position_next;
      invalid_jumps <= invalid_jumps_next;
      homing        <= homing_next;
    end
  end

  assign pos_wide = 64'(position_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pos    <= pos_wide[qcnt_pkg::OUT_POS_W-1:0];
      out_err    <= invalid_jumps_next;
      out_homing <= homing_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'd0, out_homing, out_err, out_pos};

  // error count only ever climbs
  a_err_monotonic: assert property (@(posedge clk) disable iff (rst)
    invalid_jumps >= $past(invalid_jumps))
    else $error("error count decreased");

  // homing ends only through an index sample or a clear
  a_homing_exit: assert property (@(posedge clk) disable iff (rst)
    $fell(homing) |-> $past(advance) &&
      ($past(in_item.req_type) == qcnt_pkg::REQ_CLEAR ||
       ($past(in_item.req_type) == qcnt_pkg::REQ_SAMPLE && $past(in_item.index_pulse))))
    else $error("homing dropped without index or clear");

  // input side only stalls with both stages full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_vld && out_vld && !m_tready)
    else $error("input stalled with room in the pipe");

  // a clear reports a zero position
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    advance && in_item.req_type == qcnt_pkg::REQ_CLEAR |=> out_pos == '0 && !out_homing)
    else $error("clear did not zero position");

endmodule

// ===== tb/quadrature_counter_with_homing_tb.sv =====
`timescale 1ns / 100ps

module quadrature_counter_with_homing_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] errors;
    logic        homing;
  } counter_out_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [qcnt_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [qcnt_pkg::IN_USER_W-1:0]  s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [qcnt_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [qcnt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [qcnt_pkg::CFG_DATA_W-1:0] cfg_data;

  // predictor state and its copy of the registers
  logic [1:0]   prev_phase;
  logic [31:0]  position;
  logic [31:0]  jump_errors;
  logic         homing;
  logic         reverse;
  logic [31:0]  offset;

  counter_out_t pending_counts[$];
  int unsigned  mismatches;
  int unsigned  cycles;
  bit           tx_idle_en;
  bit           rx_idle_en;
  int unsigned  rx_hold;

  quadrature_counter_with_homing uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sequence 00, 01, 11, 10 -> rank 0..3
  function automatic logic [1:0] phase_rank(input logic [1:0] ph);
    case (ph)
      2'b00: phase_rank = 2'd0;
      2'b01: phase_rank = 2'd1;
      2'b11: phase_rank = 2'd2;
      default: phase_rank = 2'd3;
    endcase
  endfunction

  function automatic counter_out_t advance_counter(input logic [1:0] req,
                                                   input logic [1:0] ph,
                                                   input logic       idx);
    logic [1:0]   delta;
    logic         up;
    logic         down;
    counter_out_t res;
    if (req == qcnt_pkg::REQ_SAMPLE) begin
      delta = phase_rank(ph) - phase_rank(prev_phase);
      up    = (delta == 2'd1);
      down  = (delta == 2'd3);
      if (delta == 2'd2 && jump_errors != 32'hFFFF_FFFF) jump_errors = jump_errors + 1;
      if (reverse) begin
        up   = (delta == 2'd3);
        down = (delta == 2'd1);
      end
      if (up) position = position + 1;
      if (down) position = position - 1;
      // index load wins over the step of the same sample
      if (homing && idx) begin
        position = offset;
        homing   = 1'b0;
      end
      prev_phase = ph;
    end else if (req == qcnt_pkg::REQ_CLEAR) begin
      position = '0;
      homing   = 1'b0;
    end else if (req == qcnt_pkg::REQ_HOME) begin
      homing = 1'b1;
    end
    res.position = position;
    res.errors   = jump_errors;
    res.homing   = homing;
    return res;
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [1:0] ph, input logic idx);
    @(negedge clk);
    if (tx_idle_en) begin
      while ($urandom_range(99) < 17) begin
        s_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    s_tvalid = 1'b1;
    s_tuser  = req;
    s_tdata  = {5'b0, idx, ph};
    do @(posedge clk); while (!s_tready);
    pending_counts.push_back(advance_counter(req, ph, idx));
  endtask

  // drop valid, let every result come back, then let the pipe settle
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input qcnt_pkg::cfg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == qcnt_pkg::CFG_COUNT_REVERSE) reverse = value[0];
    else offset = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic rev, input logic [31:0] home_pos);
    wait_idle();
    write_reg(qcnt_pkg::CFG_COUNT_REVERSE, {31'b0, rev});
    write_reg(qcnt_pkg::CFG_HOME_OFFSET, home_pos);
  endtask

  task automatic test_directed_forward();
    set_config(1'b0, 32'h7FFF_FFFF);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b01, 1'b0);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b11, 1'b0);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b10, 1'b0);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b00, 1'b0);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b10, 1'b0);  // step back
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b10, 1'b0);  // no change
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b01, 1'b0);  // two-step jump
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b10, 1'b0);  // two-step jump
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b00, 1'b1);  // index ignored, not homing
    send_item(qcnt_pkg::REQ_HOME, 2'b11, 1'b1);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b00, 1'b1);  // home load
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b01, 1'b0);  // wraps to most negative
    send_item(qcnt_pkg::REQ_CLEAR, 2'b10, 1'b1);
    send_item(REQ_UNUSED, 2'b11, 1'b1);
    send_item(qcnt_pkg::REQ_HOME, 2'b00, 1'b0);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b11, 1'b1);  // step, then home load overrides
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b11, 1'b0);
  endtask

  task automatic test_directed_reverse();
    set_config(1'b1, 32'h8000_0000);
    send_item(qcnt_pkg::REQ_HOME, 2'b01, 1'b0);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b01, 1'b1);
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b11, 1'b0);  // reversed down, wraps to max
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b01, 1'b0);
    send_item(qcnt_pkg::REQ_CLEAR, 2'b00, 1'b0);
    send_item(qcnt_pkg::REQ_HOME, 2'b10, 1'b1);
    send_item(qcnt_pkg::REQ_CLEAR, 2'b01, 1'b1);   // clear also ends homing
    send_item(qcnt_pkg::REQ_SAMPLE, 2'b00, 1'b1);
  endtask

  // Mostly legal encoder motion with random index; some jumps and commands.
  task automatic test_random_motion(input int unsigned n, input logic rev,
                                    input logic [31:0] home_pos, input bit idle);
    int unsigned pick;
    logic [1:0]  rank;
    logic [1:0]  ph;
    set_config(rev, home_pos);
    tx_idle_en = idle;
    rx_idle_en = idle;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      ph   = 2'($urandom_range(3));
      if (pick < 6) begin
        send_item(qcnt_pkg::REQ_HOME, ph, 1'($urandom_range(1)));
      end else if (pick < 9) begin
        send_item(qcnt_pkg::REQ_CLEAR, ph, 1'($urandom_range(1)));
      end else if (pick < 11) begin
        send_item(REQ_UNUSED, ph, 1'($urandom_range(1)));
      end else begin
        rank = phase_rank(prev_phase);
        if (pick < 19) rank = rank + 2'd2;
        else if (pick < 27) rank = rank;
        else if (pick < 65) rank = rank + 2'd1;
        else rank = rank - 2'd1;
        ph = {rank[1], rank[1] ^ rank[0]};
        send_item(qcnt_pkg::REQ_SAMPLE, ph, ($urandom_range(9) == 0));
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver stalls long enough for the input stage to back up.
  task automatic test_output_stall();
    logic [1:0] rank;
    wait_idle();
    tx_idle_en = 1'b0;
    rx_hold    = 60;
    for (int i = 0; i < 30; i++) begin
      rank = phase_rank(prev_phase) + 2'($urandom_range(1) ? 1 : 3);
      send_item(qcnt_pkg::REQ_SAMPLE, {rank[1], rank[1] ^ rank[0]},
                1'($urandom_range(1)));
    end
    tx_idle_en = 1'b1;
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (rx_idle_en) begin
        m_tready = ($urandom_range(99) >= 17);
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    counter_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_counts.size() == 0) begin
        $error("result beat with no expected count waiting");
        mismatches++;
      end else begin
        want = pending_counts.pop_front();
        if (m_tdata[31:0] !== want.position) begin
          $error("position_count: expected %0d, got %0d",
                 $signed(want.position), $signed(m_tdata[31:0]));
          mismatches++;
        end
        if (m_tdata[63:32] !== want.errors) begin
          $error("error_count: expected %0d, got %0d", want.errors, m_tdata[63:32]);
          mismatches++;
        end
        if (m_tdata[64] !== want.homing) begin
          $error("homing_active: expected %0b, got %0b", want.homing, m_tdata[64]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = qcnt_pkg::CFG_COUNT_REVERSE;
    cfg_data   = '0;
    prev_phase = '0;
    position   = '0;
    jump_errors = '0;
    homing     = 1'b0;
    reverse    = 1'b0;
    offset     = '0;
    mismatches = 0;
    cycles     = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_forward();
    test_directed_reverse();
    test_random_motion(240, 1'b0, $urandom, 1'b1);
    test_random_motion(240, 1'b1, 32'hFFFF_FFFF, 1'b0);
    test_output_stall();
    test_random_motion(240, 1'($urandom_range(1)), 32'h0000_0000, 1'b1);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
